FILE: design/ttfd_pkg.sv
// Package for the tag text field decoder: item structs and code constants.
// No dependencies; used by tag_text_field_decoder_unit.
package ttfd_pkg;

    // Encoding selector values carried by the first byte of a field
    localparam logic [7:0] ENC_LATIN1 = 8'h00;
    localparam logic [7:0] ENC_UTF16  = 8'h01;

    // Byte-order marks, read big-endian, and the string terminators
    localparam logic [15:0] BOM_BIG    = 16'hFEFF;
    localparam logic [15:0] BOM_LITTLE = 16'hFFFE;
    localparam logic [15:0] WORD_ZERO  = 16'h0000;
    localparam logic [7:0]  BYTE_ZERO  = 8'h00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       field_last;
    } t_in_item;

    typedef struct packed {
        logic        char_valid;
        logic [15:0] char_code;
        logic        string_end;
        logic        bad_encoding;
    } t_out_item;

endpackage

FILE: design/tag_text_field_decoder_unit.sv
// Tag text field decoder: Latin-1 / UTF-16 bytes in, character codes out.
// Depends on ttfd_pkg (item structs, encoding and marker constants).
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------------
//   in      | in        | i_in_valid / o_in_stall   | i_in_item  (t_in_item)
//   out     | out       | o_out_valid / i_out_stall | o_out_item (t_out_item)
//
// One byte per cycle sustained while the output does not stall. Each item is
// decoded in the input register and its result is loaded into the result
// register, which drives the output. Items that make no result leave the
// input register without waiting on the output side. A stall on the output
// only holds the input register when its item has a result to hand on.
// Synchronous active-low reset clears control state; the next byte after
// reset is an encoding byte.
module tag_text_field_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ttfd_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ttfd_pkg::t_out_item o_out_item
);

    typedef enum logic [1:0] {
        PH_ENC,
        PH_DATA,
        PH_SKIP
    } t_phase;

    // Decoder state
    t_phase     r_phase,   n_phase;
    logic       r_wide,    n_wide;
    logic       r_first,   n_first;
    logic       r_le,      n_le;
    logic [7:0] r_held,    n_held;
    logic       r_holding, n_holding;
    logic       r_open,    n_open;

    // Input register and result register
    logic                r_in_v;
    ttfd_pkg::t_in_item  r_in;
    logic                r_out_v;
    ttfd_pkg::t_out_item r_out;

    logic                res_v;
    ttfd_pkg::t_out_item res;
    logic                s1_move;
    logic                out_free;
    logic [15:0]         be_word;
    logic                le_now;
    logic [15:0]         word;
    logic                mark;

    assign be_word = {r_held, r_in.data_byte};

    // Decode of the byte in the input register
    always_comb begin
        n_phase   = r_phase;
        n_wide    = r_wide;
        n_first   = r_first;
        n_le      = r_le;
        n_held    = r_held;
        n_holding = r_holding;
        n_open    = r_open;
        res_v     = 1'b0;
        res       = '0;
        le_now    = r_le;
        mark      = 1'b0;
        word      = be_word;

        unique case (r_phase)
            PH_ENC: begin
                if (r_in.data_byte == ttfd_pkg::ENC_LATIN1 ||
                    r_in.data_byte == ttfd_pkg::ENC_UTF16) begin
                    n_wide    = r_in.data_byte[0];
                    n_phase   = PH_DATA;
                    n_first   = 1'b1;
                    n_holding = 1'b0;
                    n_open    = 1'b0;
                end else begin
                    res_v            = 1'b1;
                    res.bad_encoding = 1'b1;
                    n_phase          = PH_SKIP;
                end
            end
            PH_DATA: begin
                if (!r_wide) begin
                    // Latin-1: one byte, one character
                    res_v = 1'b1;
                    if (r_in.data_byte == ttfd_pkg::BYTE_ZERO) begin
                        res.string_end = 1'b1;
                        n_open         = 1'b0;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_code  = {8'h00, r_in.data_byte};
                        res.string_end = r_in.field_last;
                        n_open         = 1'b1;
                    end
                end else if (!r_holding) begin
                    // First half of a word; odd trailing byte closes an open string
                    if (r_in.field_last) begin
                        res_v          = r_open;
                        res.string_end = r_open;
                    end else begin
                        n_held    = r_in.data_byte;
                        n_holding = 1'b1;
                    end
                end else begin
                    n_holding = 1'b0;
                    if (r_first) begin
                        n_first = 1'b0;
                        le_now  = (be_word == ttfd_pkg::BOM_LITTLE);
                        mark    = (be_word == ttfd_pkg::BOM_LITTLE) ||
                                  (be_word == ttfd_pkg::BOM_BIG);
                    end
                    n_le = le_now;
                    word = le_now ? {be_word[7:0], be_word[15:8]} : be_word;
                    if (mark) begin
                        n_open         = 1'b1;
                        res_v          = r_in.field_last;
                        res.string_end = r_in.field_last;
                    end else if (word == ttfd_pkg::WORD_ZERO) begin
                        res_v          = 1'b1;
                        res.string_end = 1'b1;
                        n_open         = 1'b0;
                        n_first        = 1'b1;
                    end else begin
                        res_v          = 1'b1;
                        res.char_valid = 1'b1;
                        res.char_code  = word;
                        res.string_end = r_in.field_last;
                        n_open         = 1'b1;
                    end
                end
            end
            default: begin
                // Skipping the rest of a field with a bad encoding byte
            end
        endcase

        // Field end returns to the encoding byte
        if (r_in.field_last) begin
            n_phase   = PH_ENC;
            n_first   = 1'b1;
            n_holding = 1'b0;
            n_open    = 1'b0;
        end
    end

    // Handshake between the two registers
    assign out_free   = !r_out_v || !i_out_stall;
    assign s1_move    = !r_in_v || !res_v || out_free;
    assign o_in_stall = r_in_v && !s1_move;

    // State, input register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ENC;
            r_wide    <= 1'b0;
            r_first   <= 1'b1;
            r_le      <= 1'b0;
            r_holding <= 1'b0;
            r_open    <= 1'b0;
            r_in_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            if (r_in_v && s1_move) begin
                r_phase   <= n_phase;
                r_wide    <= n_wide;
                r_first   <= n_first;
                r_le      <= n_le;
                r_holding <= n_holding;
                r_open    <= n_open;
            end
            if (s1_move) begin
                r_in_v <= i_in_valid;
            end
            if (r_in_v && res_v && out_free) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_in_v && s1_move) begin
            r_held <= n_held;
        end
        if (s1_move) begin
            r_in <= i_in_item;
        end
        if (r_in_v && res_v && out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // An encoding error carries no character and no string end
    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.bad_encoding
        |-> !o_out_item.char_valid && !o_out_item.string_end)
        else $error("bad_encoding result with other fields set");

    // Every result is a character, a string end or an error
    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.char_valid && !o_out_item.bad_encoding
        |-> o_out_item.string_end)
        else $error("empty result item");

    // No code without a character
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.char_valid |-> o_out_item.char_code == 16'h0000)
        else $error("char_code set without char_valid");

    // A held half word exists only while decoding UTF-16 data
    a_hold_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_holding |-> r_wide && r_phase == PH_DATA)
        else $error("half word held outside UTF-16 data");

    // The input register only stalls on a pending result with a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_v && i_out_stall && res_v)
        else $error("input stalled without a blocked result");
`endif

endmodule

FILE: test/tag_text_field_decoder_unit_tb.sv
// Testbench for tag_text_field_decoder_unit: directed and random text fields
// checked against a built-in decoder model. Depends on ttfd_pkg and the unit.
`timescale 1ns / 1ps

module tag_text_field_decoder_unit_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int SEGMENT      = 425;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {
        PH_ENCODING,
        PH_TEXT,
        PH_SKIPPING
    } t_dec_phase;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    ttfd_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    ttfd_pkg::t_out_item o_out_item;

    tag_text_field_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting to be sent and decoded characters waiting to arrive
    ttfd_pkg::t_in_item  pending_bytes[$];
    ttfd_pkg::t_out_item expected_chars[$];

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int   in_gap   = 0;
    int   out_wait = 0;
    bit   in_no_idle  = 1'b0;
    bit   out_no_idle = 1'b0;
    int   mismatches  = 0;
    int   idle_cycles = 0;

    // Decoder model state, at reset values
    t_dec_phase  dec_phase      = PH_ENCODING;
    logic        dec_wide       = 1'b0;
    logic        dec_first_word = 1'b1;
    logic        dec_little     = 1'b0;
    logic [7:0]  dec_held       = 8'h00;
    logic        dec_holding    = 1'b0;
    logic        dec_open       = 1'b0;

    // Decode one byte; returns 1 when it yields a result item
    function automatic bit decode_byte(input ttfd_pkg::t_in_item it,
                                       output ttfd_pkg::t_out_item res);
        logic [15:0] be_word;
        logic [15:0] word;
        bit          mark;
        bit          got;
        got  = 1'b0;
        mark = 1'b0;
        res  = '0;
        case (dec_phase)
            PH_ENCODING: begin
                if (it.data_byte == ttfd_pkg::ENC_LATIN1 ||
                    it.data_byte == ttfd_pkg::ENC_UTF16) begin
                    dec_wide       = (it.data_byte == ttfd_pkg::ENC_UTF16);
                    dec_phase      = PH_TEXT;
                    dec_first_word = 1'b1;
                    dec_holding    = 1'b0;
                    dec_open       = 1'b0;
                end else begin
                    res.bad_encoding = 1'b1;
                    got              = 1'b1;
                    dec_phase        = PH_SKIPPING;
                end
            end
            PH_SKIPPING: begin
            end
            default: begin
                if (!dec_wide) begin
                    // Latin-1: one byte per character, zero ends the string
                    got = 1'b1;
                    if (it.data_byte == ttfd_pkg::BYTE_ZERO) begin
                        res.string_end = 1'b1;
                        dec_open       = 1'b0;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_code  = {8'h00, it.data_byte};
                        res.string_end = it.field_last;
                        dec_open       = 1'b1;
                    end
                end else if (!dec_holding) begin
                    // odd trailing byte is dropped, but closes an open string
                    if (it.field_last) begin
                        if (dec_open) begin
                            res.string_end = 1'b1;
                            got            = 1'b1;
                        end
                    end else begin
                        dec_held    = it.data_byte;
                        dec_holding = 1'b1;
                    end
                end else begin
                    dec_holding = 1'b0;
                    be_word     = {dec_held, it.data_byte};
                    if (dec_first_word) begin
                        dec_first_word = 1'b0;
                        dec_little     = 1'b0;
                        if (be_word == ttfd_pkg::BOM_BIG) begin
                            mark = 1'b1;
                        end else if (be_word == ttfd_pkg::BOM_LITTLE) begin
                            dec_little = 1'b1;
                            mark       = 1'b1;
                        end
                    end
                    word = dec_little ? {be_word[7:0], be_word[15:8]} : be_word;
                    if (mark) begin
                        dec_open = 1'b1;
                        if (it.field_last) begin
                            res.string_end = 1'b1;
                            got            = 1'b1;
                        end
                    end else if (word == ttfd_pkg::WORD_ZERO) begin
                        res.string_end = 1'b1;
                        got            = 1'b1;
                        dec_open       = 1'b0;
                        dec_first_word = 1'b1;
                    end else begin
                        res.char_valid = 1'b1;
                        res.char_code  = word;
                        res.string_end = it.field_last;
                        got            = 1'b1;
                        dec_open       = 1'b1;
                    end
                end
            end
        endcase
        // end of field: back to the encoding byte, byte order and mode kept
        if (it.field_last) begin
            dec_phase      = PH_ENCODING;
            dec_first_word = 1'b1;
            dec_held       = 8'h00;
            dec_holding    = 1'b0;
            dec_open       = 1'b0;
        end
        return got;
    endfunction

    function automatic int draw_wait(input bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, 16));
    endfunction

    task automatic report_mismatch(input string what, input ttfd_pkg::t_out_item want,
                                   input ttfd_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $write("%0t: %s: expected valid=%b code=%h end=%b bad=%b, ",
                   $realtime, what, want.char_valid, want.char_code, want.string_end,
                   want.bad_encoding);
            $display("got valid=%b code=%h end=%b bad=%b",
                     got.char_valid, got.char_code, got.string_end, got.bad_encoding);
        end
    endtask

    // Sample handshakes, predict accepted bytes, check accepted characters
    always @(posedge i_clk) begin : monitor
        ttfd_pkg::t_out_item pred;
        ttfd_pkg::t_out_item want;
        in_fire  <= i_rst_n && i_in_valid && !o_in_stall;
        out_fire <= i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (decode_byte(i_in_item, pred))
                expected_chars.push_back(pred);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected item", '0, o_out_item);
            end else begin
                want = expected_chars.pop_front();
                if (o_out_item.char_valid !== want.char_valid ||
                    o_out_item.char_code !== want.char_code ||
                    o_out_item.string_end !== want.string_end ||
                    o_out_item.bad_encoding !== want.bad_encoding)
                    report_mismatch("item mismatch", want, o_out_item);
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sender: hold the byte until taken, then wait a drawn gap
    always @(negedge i_clk) begin : drive_in
        logic               nxt_valid;
        ttfd_pkg::t_in_item nxt_item;
        nxt_valid = i_in_valid;
        nxt_item  = i_in_item;
        if (in_fire)
            nxt_valid = 1'b0;
        if (i_rst_n && !nxt_valid) begin
            if (in_gap != 0) begin
                in_gap--;
            end else if (pending_bytes.size() != 0) begin
                nxt_item  = pending_bytes.pop_front();
                nxt_valid = 1'b1;
                if ($urandom_range(0, 63) == 0)
                    in_no_idle = !in_no_idle;
                in_gap = draw_wait(in_no_idle);
            end
        end
        i_in_valid <= nxt_valid;
        i_in_item  <= nxt_item;
    end

    // Receiver: stall for a drawn count after each item, sometimes when idle
    always @(negedge i_clk) begin : drive_out
        if (out_fire) begin
            if ($urandom_range(0, 63) == 0)
                out_no_idle = !out_no_idle;
            out_wait = draw_wait(out_no_idle);
        end else if (out_wait == 0 && !out_no_idle && $urandom_range(0, 15) == 0) begin
            out_wait = draw_wait(out_no_idle);
        end
        if (out_wait != 0) begin
            i_out_stall <= 1'b1;
            out_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic push_field(input logic [7:0] bytes[$]);
        ttfd_pkg::t_in_item it;
        for (int i = 0; i < bytes.size(); i++) begin
            it.data_byte  = bytes[i];
            it.field_last = (i == bytes.size() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // Random field; returns how many bytes it queued
    task automatic gen_field(output int useful);
        logic [7:0]  fb[$];
        logic [15:0] wd;
        int          kind;
        bit          le;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            // bad encoding byte, rest skipped
            fb.push_back(8'($urandom_range(2, 255)));
            repeat ($urandom_range(0, 6)) fb.push_back(8'($urandom()));
        end else if (kind < 4) begin
            // noise after a good encoding byte
            fb.push_back(8'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 12)) fb.push_back(8'($urandom()));
        end else if (kind < 11) begin
            fb.push_back(ttfd_pkg::ENC_LATIN1);
            repeat ($urandom_range(0, 3)) begin
                repeat ($urandom_range(0, 8)) fb.push_back(8'($urandom_range(1, 255)));
                if ($urandom_range(0, 2) != 0)
                    fb.push_back(ttfd_pkg::BYTE_ZERO);
            end
        end else begin
            fb.push_back(ttfd_pkg::ENC_UTF16);
            repeat ($urandom_range(0, 3)) begin
                le = 1'b0;
                case ($urandom_range(0, 2))
                    1: begin
                        fb.push_back(ttfd_pkg::BOM_BIG[15:8]);
                        fb.push_back(ttfd_pkg::BOM_BIG[7:0]);
                    end
                    2: begin
                        fb.push_back(ttfd_pkg::BOM_LITTLE[15:8]);
                        fb.push_back(ttfd_pkg::BOM_LITTLE[7:0]);
                        le = 1'b1;
                    end
                    default: begin
                    end
                endcase
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 3) == 0)
                        wd = 16'($urandom_range(1, 255));
                    else
                        wd = 16'($urandom_range(1, 16'hFFFF));
                    if (le)
                        wd = {wd[7:0], wd[15:8]};
                    fb.push_back(wd[15:8]);
                    fb.push_back(wd[7:0]);
                end
                if ($urandom_range(0, 2) != 0) begin
                    fb.push_back(ttfd_pkg::WORD_ZERO[15:8]);
                    fb.push_back(ttfd_pkg::WORD_ZERO[7:0]);
                end
            end
            // odd trailing byte now and then
            if ($urandom_range(0, 4) == 0)
                fb.push_back(8'($urandom()));
        end
        useful = fb.size();
        push_field(fb);
    endtask

    // Wait for the sender to run dry and every character to arrive
    task automatic drain();
        while (pending_bytes.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int total;
        int seg;
        int n;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // good encoding byte that is also the last byte
        push_field('{ttfd_pkg::ENC_LATIN1});
        // empty Latin-1 string, extreme bytes, character on the last byte
        push_field('{ttfd_pkg::ENC_LATIN1, ttfd_pkg::BYTE_ZERO, 8'hFF, 8'h01});
        // bad encoding, trailing bytes ignored
        push_field('{8'hFF, 8'h00});
        push_field('{8'h02});
        // little-endian mark, word FFFF, terminator, dropped odd byte
        push_field('{ttfd_pkg::ENC_UTF16, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'h00, 8'h00,
                     8'h41});
        // byte-order mark that ends the field
        push_field('{ttfd_pkg::ENC_UTF16, 8'hFE, 8'hFF});
        // no mark, big-endian word, odd byte closing an open string
        push_field('{ttfd_pkg::ENC_UTF16, 8'h12, 8'h34, 8'h56});
        drain();

        // random fields in segments, draining between them
        total = 0;
        while (total < RANDOM_ITEMS) begin
            seg = 0;
            while (seg < SEGMENT && total + seg < RANDOM_ITEMS) begin
                gen_field(n);
                seg += n;
            end
            total += seg;
            drain();
        end

        if (mismatches == 0 && expected_chars.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/ttfd_pkg.sv
design/tag_text_field_decoder_unit.sv
test/tag_text_field_decoder_unit_tb.sv
